FILE: hw/rtl/ffra_pkg.sv
// Shared constants and types of the first-fit region allocator.
package ffra_pkg;
    localparam int unsigned MaxRegionsDefault = 32;
    localparam int unsigned AddrW = 64;
    localparam int unsigned TypeW = 4;
    localparam int unsigned PagesW = 20;
    localparam int unsigned PageShift = 12;
    localparam logic [TypeW-1:0] Usable = 4'd1;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [TypeW-1:0] t_rtype;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;
endpackage

FILE: hw/rtl/first_fit_region_allocator_core.sv
// Top level of the first-fit region allocator with coalescing free.
//
//  channel  | handshake           | ports
//  ---------+---------------------+--------------------------------------------
//  command  | i_start & !o_busy   | i_kind i_region_base i_region_size
//           |                     | i_region_type i_page_count
//  result   | o_done (one cycle)  | o_status o_granted_base o_granted_size
//           |                     | o_granted_type
//
// An add or an unused kind goes straight to the result. An allocate or a free scans the
// table entries one at a time through the single table read port, and a shift on remove
// or head insert moves one entry at a time through the same port. o_busy holds off new
// words until the word in progress has given its result.
// Reset clears the entry count and the sequencer; table contents are not reset.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module first_fit_region_allocator_core #(
    parameter int unsigned MAX_REGIONS = ffra_pkg::MaxRegionsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_kind,
    input  ffra_pkg::t_addr       i_region_base,
    input  ffra_pkg::t_addr       i_region_size,
    input  ffra_pkg::t_rtype      i_region_type,
    input  logic [ffra_pkg::PagesW-1:0] i_page_count,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output ffra_pkg::t_addr       o_granted_base,
    output ffra_pkg::t_addr       o_granted_size,
    output ffra_pkg::t_rtype      o_granted_type
);
    import ffra_pkg::*;

    localparam int unsigned IdxW = $clog2(MAX_REGIONS);
    localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_REGIONS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_DRD, S_DWR, S_IRD, S_IWR, S_HEAD, S_RESP
    } t_state;

    t_state           r_state;
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  r_idx;
    t_kind            r_kind;
    t_addr            r_base, r_size, r_want;
    t_rtype           r_type;
    logic [1:0]       r_status;
    t_addr            r_gbase, r_gsize;
    t_rtype           r_gtype;
    logic             r_done;

    logic             w_we;
    logic [IdxW-1:0]  w_waddr, w_raddr;
    t_addr            w_wbase, w_wsize, w_rbase, w_rsize;
    t_rtype           w_wtype, w_rtype;
    t_addr            w_end, w_diff;

    ffra_table #(.DEPTH(MAX_REGIONS)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wbase(w_wbase),
        .i_wsize(w_wsize),
        .i_wtype(w_wtype),
        .i_raddr(w_raddr),
        .o_rbase(w_rbase),
        .o_rsize(w_rsize),
        .o_rtype(w_rtype)
    );

    // Separate adder and subtractor: entry end on the scan, remainder on an allocate.
    assign w_end  = w_rbase + w_rsize;
    assign w_diff = w_rsize - r_want;

    // Read address: the scan entry, the shift-down source, or the shift-up source.
    always_comb begin
        case (r_state)
            S_DRD:   w_raddr = IdxW'(r_idx + 1'b1);
            S_IRD:   w_raddr = IdxW'(r_idx - 1'b1);
            default: w_raddr = r_idx[IdxW-1:0];
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IdxW-1:0];
        w_wbase = w_rbase;
        w_wsize = w_rsize;
        w_wtype = w_rtype;
        case (r_state)
            S_IDLE: begin
                w_waddr = r_count[IdxW-1:0];
                w_wbase = i_region_base;
                w_wsize = i_region_size;
                w_wtype = i_region_type;
                w_we = i_start && t_kind'(i_kind) == KIND_ADD &&
                       i_region_base != '0 && r_count != CntMax;
            end
            S_CHK: begin
                // Past the last entry the read data is stale and must not be written back.
                if (r_idx == r_count) begin
                    w_we = 1'b0;
                end else if (r_kind == KIND_ALLOC) begin
                    w_wsize = w_diff;
                    w_we = w_rtype == Usable && w_rsize > r_want;
                end else if (w_end == r_base) begin
                    w_wsize = w_rsize + r_size;
                    w_we = 1'b1;
                end else if (r_base + r_size == w_rbase) begin
                    w_wbase = r_base;
                    w_wsize = w_rsize + r_size;
                    w_we = 1'b1;
                end
            end
            S_DWR, S_IWR: w_we = 1'b1;
            S_HEAD: begin
                w_waddr = '0;
                w_wbase = r_base;
                w_wsize = r_size;
                w_wtype = r_type;
                w_we = 1'b1;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_done   <= 1'b0;
            r_kind   <= KIND_NONE;
            r_status <= ST_DONE;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind   <= t_kind'(i_kind);
                        r_base   <= i_region_base;
                        r_size   <= i_region_size;
                        r_type   <= i_region_type;
                        r_want   <= {{(AddrW-PagesW-PageShift){1'b0}}, i_page_count,
                                     {PageShift{1'b0}}};
                        r_status <= ST_DONE;
                        r_gbase  <= '0;
                        r_gsize  <= '0;
                        r_gtype  <= '0;
                        r_idx    <= '0;
                        case (t_kind'(i_kind))
                            KIND_ADD: begin
                                if (i_region_base != '0) begin
                                    if (r_count == CntMax) r_status <= ST_FULL;
                                    else r_count <= r_count + 1'b1;
                                end
                                r_state <= S_RESP;
                            end
                            KIND_ALLOC, KIND_FREE: begin
                                r_state <= (r_count == '0) ? S_CHK : S_RD;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_idx == r_count) begin
                        // Scan ran off the end without a hit.
                        if (r_kind == KIND_ALLOC) begin
                            r_status <= ST_NOFIT;
                            r_state  <= S_RESP;
                        end else if (r_count == CntMax) begin
                            r_status <= ST_FULL;
                            r_state  <= S_RESP;
                        end else begin
                            r_idx   <= r_count;
                            r_state <= (r_count == '0) ? S_HEAD : S_IRD;
                        end
                    end else if (r_kind == KIND_ALLOC) begin
                        if (w_rtype == Usable && w_rsize >= r_want) begin
                            r_gsize <= r_want;
                            r_gtype <= w_rtype;
                            if (w_rsize == r_want) begin
                                r_gbase <= w_rbase;
                                if (r_idx + 1'b1 == r_count) begin
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_DRD;
                                end
                            end else begin
                                r_gbase <= w_rbase + w_diff;
                                r_state <= S_RESP;
                            end
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= (r_idx + 1'b1 == r_count) ? S_CHK : S_RD;
                        end
                    end else if (w_we) begin
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= (r_idx + 1'b1 == r_count) ? S_CHK : S_RD;
                    end
                end
                S_DRD: r_state <= S_DWR;
                S_DWR: begin
                    if (r_idx + 2'd2 >= {1'b0, r_count}) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_IRD: r_state <= S_IWR;
                S_IWR: begin
                    r_idx   <= r_idx - 1'b1;
                    r_state <= (r_idx == CntW'(1)) ? S_HEAD : S_IRD;
                end
                S_HEAD: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_base = r_gbase;
    assign o_granted_size = r_gsize;
    assign o_granted_type = r_gtype;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax) else $error("entry count beyond table depth");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("result while still working");
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_status != ST_DONE |-> r_gsize == '0 && r_gbase == '0)
        else $error("grant on failed word");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && i_start |=> r_state != S_IDLE)
        else $error("accepted word did not start the sequencer");
endmodule

FILE: hw/rtl/ffra_table.sv
// Region table memory: one write port and one registered read port.
module ffra_table #(
    parameter int unsigned DEPTH = ffra_pkg::MaxRegionsDefault
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ffra_pkg::t_addr          i_wbase,
    input  ffra_pkg::t_addr          i_wsize,
    input  ffra_pkg::t_rtype         i_wtype,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ffra_pkg::t_addr          o_rbase,
    output ffra_pkg::t_addr          o_rsize,
    output ffra_pkg::t_rtype         o_rtype
);
    import ffra_pkg::*;

    t_addr  r_base [DEPTH];
    t_addr  r_size [DEPTH];
    t_rtype r_type [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_base[i_waddr] <= i_wbase;
            r_size[i_waddr] <= i_wsize;
            r_type[i_waddr] <= i_wtype;
        end
        o_rbase <= r_base[i_raddr];
        o_rsize <= r_size[i_raddr];
        o_rtype <= r_type[i_raddr];
    end
endmodule
